/* hdl/wcs_pkg.sv */
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared constants and types for the weighted category sampler.
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int MAX_CATEGORIES = 256;
    localparam int IDX_W          = $clog2(MAX_CATEGORIES);
    localparam int CNT_W          = $clog2(MAX_CATEGORIES + 1);

    localparam int VAL_W          = 16;
    localparam int CAT_W          = 8;
    localparam int PROD_W         = 2 * VAL_W;
    localparam int TOTAL_W        = 40;
    localparam int HALF_W         = TOTAL_W / 2;
    localparam int PP_W           = HALF_W + VAL_W;
    localparam int TARGET_W       = TOTAL_W + VAL_W;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic              row_last;
        logic [VAL_W-1:0]  uniform_draw;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

endpackage

/* hdl/wcs_channels.sv */
// ----------------------------------------------------------------------------
// wcs_channels
// Valid/ready channels for sampler input and result transactions.
// ----------------------------------------------------------------------------
interface wcs_in_if;
    logic                       valid;
    logic                       ready;
    logic [wcs_pkg::VAL_W-1:0]  probability;
    logic [wcs_pkg::VAL_W-1:0]  weight;
    logic                       row_last;
    logic [wcs_pkg::VAL_W-1:0]  uniform_draw;

    modport source (output valid, probability, weight, row_last, uniform_draw,
                    input ready);
    modport sink   (input valid, probability, weight, row_last, uniform_draw,
                    output ready);
endinterface

interface wcs_out_if;
    logic                       valid;
    logic                       ready;
    logic [wcs_pkg::CAT_W-1:0]  chosen_category;
    logic                       zero_total;

    modport source (output valid, chosen_category, zero_total, input ready);
    modport sink   (input valid, chosen_category, zero_total, output ready);
endinterface

/* hdl/wcs_ram.sv */
// ----------------------------------------------------------------------------
// wcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/wcs_front.sv */
// ----------------------------------------------------------------------------
// wcs_front
// Accepts input transactions and forms the weighted product for the queue.
// ----------------------------------------------------------------------------
module wcs_front (
    input  logic            clk,
    input  logic            rst_n,
    wcs_in_if.sink          sample_in,
    output wcs_pkg::entry_t push_entry,
    output logic            push_valid,
    input  logic            push_ready
);

    logic            stage_valid_reg;
    logic            stage_valid_next;
    wcs_pkg::entry_t stage_entry_reg;
    logic            accept;

    assign sample_in.ready = !stage_valid_reg || push_ready;
    assign accept          = sample_in.valid && sample_in.ready;
    assign push_valid      = stage_valid_reg;
    assign push_entry      = stage_entry_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_entry_reg.product      <= wcs_pkg::PROD_W'(sample_in.probability)
                                          * wcs_pkg::PROD_W'(sample_in.weight);
            stage_entry_reg.row_last     <= sample_in.row_last;
            stage_entry_reg.uniform_draw <= sample_in.uniform_draw;
        end
    end

endmodule

/* hdl/wcs_queue.sv */
// ----------------------------------------------------------------------------
// wcs_queue
// Short flop FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module wcs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  wcs_pkg::entry_t     push_entry,
    input  logic                push_valid,
    output logic                push_ready,
    output wcs_pkg::queue_head_t head,
    input  logic                pop
);

    wcs_pkg::entry_t                mem_reg [wcs_pkg::QUEUE_DEPTH];
    logic [wcs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [wcs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [wcs_pkg::QCNT_W-1:0]     cnt_reg;
    logic [wcs_pkg::QCNT_W-1:0]     cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready  = cnt_reg < wcs_pkg::QCNT_W'(wcs_pkg::QUEUE_DEPTH);
    assign do_push     = push_valid && push_ready;
    assign do_pop      = pop && head.valid;
    assign head.valid  = cnt_reg != '0;
    assign head.entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/wcs_back.sv */
// ----------------------------------------------------------------------------
// wcs_back
// Stores products, keeps the row total and walks the cumulative sum at
// the end of a row to pick the category; a zero-total row skips the walk.
// ----------------------------------------------------------------------------
module wcs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wcs_pkg::queue_head_t head,
    output logic                 pop,
    wcs_out_if.source            sample_out
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_MUL,
        S_SUM,
        S_WALK,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [wcs_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [wcs_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [wcs_pkg::VAL_W-1:0]       draw_reg, draw_next;
    logic [wcs_pkg::PP_W-1:0]        pp_lo_reg, pp_lo_next;
    logic [wcs_pkg::PP_W-1:0]        pp_hi_reg, pp_hi_next;
    logic [wcs_pkg::TARGET_W-1:0]    target_reg, target_next;
    logic [wcs_pkg::TOTAL_W-1:0]     cum_reg, cum_next;
    logic [wcs_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [wcs_pkg::IDX_W-1:0]       pick_reg, pick_next;
    logic                            zero_reg, zero_next;
    logic                            out_valid_reg, out_valid_next;
    logic [wcs_pkg::CAT_W-1:0]       out_cat_reg, out_cat_next;
    logic                            out_zero_reg, out_zero_next;

    logic                            store_en;
    logic                            rd_en;
    logic [wcs_pkg::IDX_W-1:0]       rd_addr;
    logic [wcs_pkg::PROD_W-1:0]      rd_data;
    logic [wcs_pkg::TOTAL_W-1:0]     cum_sum;
    logic                            walk_hit;
    logic                            walk_end;
    logic                            out_free;

    assign pop      = (state_reg == S_LOAD) && head.valid;
    assign store_en = pop && (count_reg < wcs_pkg::CNT_W'(wcs_pkg::MAX_CATEGORIES));
    assign rd_en    = (state_reg == S_SUM) || (state_reg == S_WALK);
    assign rd_addr  = (state_reg == S_SUM) ? '0 : idx_reg + 1'b1;
    assign cum_sum  = cum_reg + wcs_pkg::TOTAL_W'(rd_data);
    assign walk_hit = {cum_sum, {wcs_pkg::VAL_W{1'b0}}} >= target_reg;
    assign walk_end = {1'b0, idx_reg} == count_reg - 1'b1;
    assign out_free = !out_valid_reg || sample_out.ready;

    assign sample_out.valid           = out_valid_reg;
    assign sample_out.chosen_category = out_cat_reg;
    assign sample_out.zero_total      = out_zero_reg;

    wcs_ram #(
        .WIDTH (wcs_pkg::PROD_W),
        .DEPTH (wcs_pkg::MAX_CATEGORIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (count_reg[wcs_pkg::IDX_W-1:0]),
        .wr_data (head.entry.product),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        draw_next      = draw_reg;
        pp_lo_next     = pp_lo_reg;
        pp_hi_next     = pp_hi_reg;
        target_next    = target_reg;
        cum_next       = cum_reg;
        idx_next       = idx_reg;
        pick_next      = pick_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_cat_next   = out_cat_reg;
        out_zero_next  = out_zero_reg;

        if (sample_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (store_en)
                begin
                    total_next = total_reg + wcs_pkg::TOTAL_W'(head.entry.product);
                    count_next = count_reg + 1'b1;
                end
                if (pop && head.entry.row_last)
                begin
                    draw_next  = head.entry.uniform_draw;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                pp_lo_next = wcs_pkg::PP_W'(draw_reg)
                           * wcs_pkg::PP_W'(total_reg[wcs_pkg::HALF_W-1:0]);
                pp_hi_next = wcs_pkg::PP_W'(draw_reg)
                           * wcs_pkg::PP_W'(total_reg[wcs_pkg::TOTAL_W-1:wcs_pkg::HALF_W]);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                target_next = {pp_hi_reg, {wcs_pkg::HALF_W{1'b0}}}
                            + wcs_pkg::TARGET_W'(pp_lo_reg);
                cum_next    = '0;
                idx_next    = '0;
                pick_next   = '0;
                if (total_reg == '0 || count_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cum_next = cum_sum;
                idx_next = idx_reg + 1'b1;
                if (walk_hit || walk_end)
                begin
                    pick_next  = idx_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cat_next   = wcs_pkg::CAT_W'(pick_reg);
                    out_zero_next  = zero_reg;
                    total_next     = '0;
                    count_next     = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            total_reg     <= '0;
            count_reg     <= '0;
            draw_reg      <= '0;
            pp_lo_reg     <= '0;
            pp_hi_reg     <= '0;
            target_reg    <= '0;
            cum_reg       <= '0;
            idx_reg       <= '0;
            pick_reg      <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_cat_reg   <= '0;
            out_zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            draw_reg      <= draw_next;
            pp_lo_reg     <= pp_lo_next;
            pp_hi_reg     <= pp_hi_next;
            target_reg    <= target_next;
            cum_reg       <= cum_next;
            idx_reg       <= idx_next;
            pick_reg      <= pick_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
            out_cat_reg   <= out_cat_next;
            out_zero_reg  <= out_zero_next;
        end
    end

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> count_reg != '0 && total_reg != '0)
        else $error("walk started on an empty row");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> {1'b0, idx_reg} < count_reg)
        else $error("walk index past last stored category");

    a_zero_picks_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_zero_reg |-> out_cat_reg == '0)
        else $error("zero total must pick category 0");

    a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_free |=> count_reg == '0 && total_reg == '0)
        else $error("row state not cleared after result");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_LOAD |-> !pop)
        else $error("queue popped outside load");

endmodule

/* hdl/weighted_category_sampler.sv */
// Path: front product register, queue, row load, then S_MUL, S_SUM, S_WALK and S_DONE;
//   a zero-total row skips S_WALK, and the walk lasts longer the more categories it passes.
// Throughput: one transaction per cycle while a row loads; during the end-of-row walk
//   of the product RAM (one read per cycle) and the result hand-off, input stalls once the queue fills.
// Reset: rst_n clears the row total, item count, queue and output valid; RAM is not cleared.
// ----------------------------------------------------------------------------
// weighted_category_sampler
// Roulette-wheel category sampler by inverse cumulative sum.
// ----------------------------------------------------------------------------
module weighted_category_sampler (
    input  logic      clk,
    input  logic      rst_n,
    wcs_in_if.sink    sample_in,
    wcs_out_if.source sample_out
);

    wcs_pkg::entry_t      push_entry;
    logic                 push_valid;
    logic                 push_ready;
    wcs_pkg::queue_head_t head;
    logic                 pop;

    wcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    wcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    wcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .sample_out (sample_out)
    );

endmodule
